// File: rtl/fpa_pkg.sv
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared widths, opcodes and pipeline word types for the Q24.8 ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

    localparam int DW         = 32;
    localparam int FB         = 8;
    localparam int NUMW       = DW + FB;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = NUMW / DIV_STEP;

    typedef enum logic [2:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_CMP = 3'd4,
        OP_MIN = 3'd5,
        OP_MAX = 3'd6
    } op_t;

    // restoring divider state
    typedef struct packed {
        logic [DW-1:0]   rem;
        logic [NUMW-1:0] num;
        logic [DW-1:0]   quo;
        logic [DW-1:0]   den;
    } div_t;

    // everything that rides alongside the divider
    typedef struct packed {
        logic [2:0]    op;
        logic [DW-1:0] res;
        logic [DW-1:0] mul;
        logic          neg;
        logic          gt;
        logic          lt;
        logic          eq;
        logic          dz;
    } side_t;

endpackage

// File: rtl/fixed_point_q24_8_alu_unit.sv
// ----------------------------------------------------------------------------
// fixed_point_q24_8_alu_unit
// Pipelined signed Q24.8 ALU: add, sub, mul, div, compare, min, max.
// ----------------------------------------------------------------------------
// Takes one word per cycle while s_tready is high and returns one word per
// request, in order. The divider has ten stages of four quotient bits each;
// every operation goes through the same pipeline. A stall on m_tready freezes
// the whole pipeline and deasserts s_tready. Divide by zero returns 0 with
// divide_by_zero set; the compare flags are valid for every request.
module fixed_point_q24_8_alu_unit import fpa_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] req_type, [34:3] operand_a, [66:35] operand_b, [71:67] zero
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [31:0] result_raw, [32] is_greater, [33] is_less, [34] is_equal,
    // [35] divide_by_zero, [39:36] zero
    output logic [39:0] m_tdata
);

    logic en;

    // stage 0: capture, magnitudes
    logic          v0_reg;
    logic [2:0]    op0_reg;
    logic [DW-1:0] a0_reg, b0_reg, ax0_reg, bx0_reg;

    // stage 1: multiply, compare, add/sub, min/max, divider load
    logic          v1_reg;
    side_t         side1_reg, side1_next;
    div_t          div1_reg, div1_next;

    logic [DIV_STAGES-1:0] v_reg;
    side_t                 side_reg [DIV_STAGES];
    div_t                  div_w    [DIV_STAGES+1];

    logic          m_valid_reg;
    logic [39:0]   m_data_reg, m_data_next;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v0_reg      <= s_tvalid;
            v1_reg      <= v0_reg;
            v_reg       <= {v_reg[DIV_STAGES-2:0], v1_reg};
            m_valid_reg <= v_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            op0_reg <= s_tdata[2:0];
            a0_reg  <= s_tdata[DW+2:3];
            b0_reg  <= s_tdata[2*DW+2:DW+3];
            ax0_reg <= s_tdata[DW+2]   ? DW'(-s_tdata[DW+2:3])      : s_tdata[DW+2:3];
            bx0_reg <= s_tdata[2*DW+2] ? DW'(-s_tdata[2*DW+2:DW+3]) : s_tdata[2*DW+2:DW+3];
        end
    end

    always_comb begin
        logic [2*DW-1:0] prod;
        prod           = ax0_reg * bx0_reg;
        side1_next.op  = op0_reg;
        side1_next.gt  = $signed(a0_reg) > $signed(b0_reg);
        side1_next.lt  = $signed(a0_reg) < $signed(b0_reg);
        side1_next.eq  = a0_reg == b0_reg;
        side1_next.neg = a0_reg[DW-1] ^ b0_reg[DW-1];
        side1_next.mul = prod[DW+FB-1:FB];
        side1_next.dz  = (op_t'(op0_reg) == OP_DIV) && (b0_reg == '0);
        case (op_t'(op0_reg))
            OP_ADD:  side1_next.res = a0_reg + b0_reg;
            OP_SUB:  side1_next.res = a0_reg - b0_reg;
            OP_MIN:  side1_next.res = side1_next.lt ? a0_reg : b0_reg;
            OP_MAX:  side1_next.res = side1_next.gt ? a0_reg : b0_reg;
            default: side1_next.res = a0_reg;
        endcase
        div1_next.rem = '0;
        div1_next.num = {ax0_reg, {FB{1'b0}}};
        div1_next.quo = '0;
        div1_next.den = bx0_reg;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side1_reg <= side1_next;
            div1_reg  <= div1_next;
        end
    end

    assign div_w[0] = div1_reg;

    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        fpa_div_stage u_stage (
            .aclk  (aclk),
            .en    (en),
            .d_in  (div_w[k]),
            .d_out (div_w[k+1])
        );

        always_ff @(posedge aclk) begin
            if (en) begin
                side_reg[k] <= (k == 0) ? side1_reg : side_reg[(k == 0) ? 0 : k-1];
            end
        end
    end

    always_comb begin
        side_t         sd;
        logic [DW-1:0] q;
        logic [DW-1:0] r;
        sd = side_reg[DIV_STAGES-1];
        q  = div_w[DIV_STAGES].quo;
        case (op_t'(sd.op))
            OP_MUL:  r = sd.neg ? DW'(-sd.mul) : sd.mul;
            OP_DIV:  r = sd.dz ? '0 : (sd.neg ? DW'(-q) : q);
            default: r = sd.res;
        endcase
        m_data_next = {4'b0, sd.dz, sd.eq, sd.lt, sd.gt, r};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

// File: rtl/fpa_div_stage.sv
// ----------------------------------------------------------------------------
// fpa_div_stage
// One registered stage of the unsigned restoring divider, DIV_STEP bits.
// ----------------------------------------------------------------------------
module fpa_div_stage import fpa_pkg::*; (
    input  logic aclk,
    input  logic en,
    input  div_t d_in,
    output div_t d_out
);

    div_t d_reg;
    div_t d_next;

    always_comb begin
        logic [DW:0]     t;
        logic [DW:0]     diff;
        logic [DW-1:0]   r;
        logic [NUMW-1:0] n;
        logic [DW-1:0]   q;
        r = d_in.rem;
        n = d_in.num;
        q = d_in.quo;
        for (int i = 0; i < DIV_STEP; i++) begin
            t    = {r, n[NUMW-1]};
            n    = {n[NUMW-2:0], 1'b0};
            diff = t - {1'b0, d_in.den};
            if (!diff[DW]) begin
                r = diff[DW-1:0];
                q = {q[DW-2:0], 1'b1};
            end else begin
                r = t[DW-1:0];
                q = {q[DW-2:0], 1'b0};
            end
        end
        d_next.rem = r;
        d_next.num = n;
        d_next.quo = q;
        d_next.den = d_in.den;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign d_out = d_reg;

endmodule
